FILE: hw/rtl/bcl_pkg.sv
package bcl_pkg;

    // Field widths fixed by the interface.
    localparam int OFFSET_W = 64;
    localparam int BASE_W   = 60;
    localparam int TAG_W    = 61;  // 60-bit aligned offset plus one carry bit
    localparam int TAG_OUT_W = 64;
    localparam int FETCH_W  = 52;
    localparam int BIB_W    = 14;
    localparam int WAYIDX_W = 3;
    localparam int CFG_W    = 64;
    localparam int PADDR_W  = 4;

    // Zone number of the raw volume, which is not rebased.
    localparam logic [3:0] RAW_ZONE = 4'd1;

    // Register index, taken from paddr[3] (registers sit 8 bytes apart).
    localparam logic CFG_IDX_BUFFER_BASE = 1'b0;

    typedef struct packed {
        logic load;    // capture the request and reset the scan
        logic issue;   // read the next way from the tag and stamp RAMs
        logic commit;  // write back the chosen way and load the result
    } cmd_t;

    typedef struct packed {
        logic issue_last;  // the way being read now is the last one
    } sts_t;

endpackage

FILE: hw/rtl/bcl_ram.sv
module bcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bcl_datapath.sv
module bcl_datapath #(
    parameter int WAYS        = 6,
    parameter int BLOCK_BYTES = 16384,
    parameter int STAMP_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bcl_pkg::cmd_t                  cmd,
    output bcl_pkg::sts_t                  sts,
    input  logic [bcl_pkg::OFFSET_W-1:0]   disk_offset,
    input  logic [bcl_pkg::BASE_W-1:0]     buffer_base,
    output logic                           hit,
    output logic [bcl_pkg::WAYIDX_W-1:0]   way_index,
    output logic [bcl_pkg::TAG_OUT_W-1:0]  block_tag,
    output logic [bcl_pkg::FETCH_W-1:0]    fetch_offset,
    output logic [bcl_pkg::BIB_W-1:0]      byte_in_block,
    output logic                           stamp_wrapped
);

    localparam int WAY_W = $clog2(WAYS);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
    localparam logic [bcl_pkg::OFFSET_W-1:0] BLK_MASK = bcl_pkg::OFFSET_W'(BLOCK_BYTES - 1);
    localparam logic [bcl_pkg::BIB_W-1:0] BIB_MASK = bcl_pkg::BIB_W'(BLOCK_BYTES - 1);

    // Request capture.
    logic [bcl_pkg::TAG_W-1:0]  tag_reg;
    logic [bcl_pkg::BIB_W-1:0]  bib_reg;
    logic [bcl_pkg::OFFSET_W-1:0] aligned;
    logic [bcl_pkg::TAG_W-1:0]  tag_calc;

    // Scan state.
    logic [WAYS-1:0]       valid_reg;
    logic [WAY_W-1:0]      rd_idx_reg;
    logic [WAY_W-1:0]      rd_idx_next;
    logic                  rd_vld_reg;
    logic                  cmp_vld_reg;
    logic [WAY_W-1:0]      cmp_idx_reg;
    logic                  found_reg;
    logic [WAY_W-1:0]      hit_idx_reg;
    logic [STAMP_BITS-1:0] min_stamp_reg;
    logic [WAY_W-1:0]      min_idx_reg;
    logic [STAMP_BITS-1:0] use_cnt_reg;
    logic [STAMP_BITS-1:0] use_cnt_next;

    // RAM read data and compare terms.
    logic [bcl_pkg::TAG_W-1:0] tag_rdata;
    logic [STAMP_BITS-1:0]     stamp_rdata;
    logic [STAMP_BITS-1:0]     stamp_eff;
    logic                      match;
    logic [WAY_W-1:0]          pick;

    // Result register.
    logic                           hit_reg;
    logic [bcl_pkg::WAYIDX_W-1:0]   way_index_reg;
    logic [bcl_pkg::TAG_OUT_W-1:0]  block_tag_reg;
    logic [bcl_pkg::FETCH_W-1:0]    fetch_offset_reg;
    logic [bcl_pkg::BIB_W-1:0]      byte_in_block_reg;
    logic                           stamp_wrapped_reg;

    always_comb
    begin
        aligned = disk_offset & ~BLK_MASK;
        if (disk_offset[63:60] != bcl_pkg::RAW_ZONE)
        begin
            tag_calc = {1'b0, aligned[59:0]} + {1'b0, buffer_base};
        end
        else
        begin
            tag_calc = {1'b0, aligned[59:0]};
        end
    end

    assign rd_idx_next  = rd_idx_reg + WAY_W'(1);
    assign use_cnt_next = use_cnt_reg + STAMP_BITS'(1);
    assign sts.issue_last = (rd_idx_reg == LAST_WAY);

    // A way never written reads as an invalid tag with a zero stamp.
    assign stamp_eff = rd_vld_reg ? stamp_rdata : '0;
    assign match     = rd_vld_reg && (tag_rdata == tag_reg);
    assign pick      = found_reg ? hit_idx_reg : min_idx_reg;

    bcl_ram #(
        .WIDTH (bcl_pkg::TAG_W),
        .DEPTH (WAYS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.commit && !found_reg),
        .waddr (pick),
        .wdata (tag_reg),
        .re    (cmd.issue),
        .raddr (rd_idx_reg),
        .rdata (tag_rdata)
    );

    bcl_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (WAYS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (pick),
        .wdata (use_cnt_next),
        .re    (cmd.issue),
        .raddr (rd_idx_reg),
        .rdata (stamp_rdata)
    );

    // Control state of the scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            use_cnt_reg <= '0;
        end
        else
        begin
            cmp_vld_reg <= cmd.issue;
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    rd_idx_reg <= rd_idx_next;
                end
                if (cmp_vld_reg && match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                valid_reg[pick] <= 1'b1;
                use_cnt_reg     <= use_cnt_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg <= tag_calc;
            bib_reg <= disk_offset[bcl_pkg::BIB_W-1:0] & BIB_MASK;
        end
        if (cmd.issue)
        begin
            rd_vld_reg  <= valid_reg[rd_idx_reg];
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmp_vld_reg)
        begin
            // The first match wins; later matches cannot occur for a valid tag.
            if (match && !found_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            // Strictly smaller keeps the lowest way on ties.
            if (cmp_idx_reg == '0 || stamp_eff < min_stamp_reg)
            begin
                min_stamp_reg <= stamp_eff;
                min_idx_reg   <= cmp_idx_reg;
            end
        end
        if (cmd.commit)
        begin
            hit_reg           <= found_reg;
            way_index_reg     <= bcl_pkg::WAYIDX_W'(pick);
            block_tag_reg     <= bcl_pkg::TAG_OUT_W'(tag_reg);
            fetch_offset_reg  <= tag_reg[bcl_pkg::FETCH_W-1:0];
            byte_in_block_reg <= bib_reg;
            stamp_wrapped_reg <= (use_cnt_next == '0);
        end
    end

    assign hit           = hit_reg;
    assign way_index     = way_index_reg;
    assign block_tag     = block_tag_reg;
    assign fetch_offset  = fetch_offset_reg;
    assign byte_in_block = byte_in_block_reg;
    assign stamp_wrapped = stamp_wrapped_reg;

`ifndef ASSERT_OFF
    // The last way's compare must be folded in before the way is chosen.
    a_no_commit_during_compare: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> !cmd.commit)
        else $error("commit while a way compare is still pending");
`endif

endmodule

FILE: hw/rtl/bcl_ctrl.sv
module bcl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bcl_pkg::cmd_t cmd,
    input  bcl_pkg::sts_t sts
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    a_one_lookup_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word accepted before the lookup finished");
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("result register overwritten while still waiting");
    a_commands_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.issue, cmd.commit}))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

FILE: hw/rtl/block_cache_lru_lookup.sv
// Lookups run one at a time: capture, a scan of every way, a drain state, then commit.
// The scan reads the tag and stamp RAMs one way per cycle through their single
//   read port.
// Reset (rst_n, asynchronous, active low): every way reads as invalid with a zero stamp
//   through per-way valid flops, the use counter and buffer_base clear to zero, and the
//   block takes requests as soon as reset is released, with no clearing pass.
module block_cache_lru_lookup #(
    parameter int WAYS        = 6,
    parameter int BLOCK_BYTES = 16384,
    parameter int STAMP_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcl_pkg::PADDR_W-1:0]    paddr,
    input  logic [bcl_pkg::CFG_W-1:0]      pwdata,
    output logic [bcl_pkg::CFG_W-1:0]      prdata,
    output logic                           pready,

    // Request channel: one disk offset per word.
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [bcl_pkg::OFFSET_W-1:0]   disk_offset,

    // Result channel: one word per lookup.
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           hit,
    output logic [bcl_pkg::WAYIDX_W-1:0]   way_index,
    output logic [bcl_pkg::TAG_OUT_W-1:0]  block_tag,
    output logic [bcl_pkg::FETCH_W-1:0]    fetch_offset,
    output logic [bcl_pkg::BIB_W-1:0]      byte_in_block,
    output logic                           stamp_wrapped
);

    // The only register, buffer_base, sits at byte address 0. Registers are 8 bytes
    // apart, so paddr[3] is the register index and a write with it set is dropped.
    // Bits above bit 59 of the written word are discarded.
    logic [bcl_pkg::BASE_W-1:0] buffer_base_reg;
    logic                       cfg_write;

    bcl_pkg::cmd_t cmd;
    bcl_pkg::sts_t sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_base_reg <= '0;
        end
        else if (cfg_write && paddr[3] == bcl_pkg::CFG_IDX_BUFFER_BASE)
        begin
            buffer_base_reg <= pwdata[bcl_pkg::BASE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == bcl_pkg::CFG_IDX_BUFFER_BASE)
        begin
            prdata = bcl_pkg::CFG_W'(buffer_base_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // The controller sequences each lookup: capture the request, read every way
    // once, let the final compare settle, then commit the chosen way and load the
    // result register. The result register frees the request side, so a new word
    // is taken while the previous result still waits on rsp_ready.
    bcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath forms the block tag (aligned, rebased outside the raw-volume
    // zone), scans the ways for the first matching tag while tracking the first
    // smallest use stamp, and on commit writes the new stamp and, on a miss, the tag.
    bcl_datapath #(
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .STAMP_BITS  (STAMP_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .disk_offset   (disk_offset),
        .buffer_base   (buffer_base_reg),
        .hit           (hit),
        .way_index     (way_index),
        .block_tag     (block_tag),
        .fetch_offset  (fetch_offset),
        .byte_in_block (byte_in_block),
        .stamp_wrapped (stamp_wrapped)
    );

endmodule

FILE: sim/lru_lookup_checker.sv
module lru_lookup_checker #(
    parameter int WAYS        = 6,
    parameter int BLOCK_BYTES = 16384,
    parameter int STAMP_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bcl_pkg::PADDR_W-1:0]       paddr,
    input  logic [bcl_pkg::CFG_W-1:0]         pwdata,
    input  logic [bcl_pkg::CFG_W-1:0]         prdata,
    input  logic                              pready,

    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic [bcl_pkg::OFFSET_W-1:0]      disk_offset,

    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic                              hit,
    input  logic [bcl_pkg::WAYIDX_W-1:0]      way_index,
    input  logic [bcl_pkg::TAG_OUT_W-1:0]     block_tag,
    input  logic [bcl_pkg::FETCH_W-1:0]       fetch_offset,
    input  logic [bcl_pkg::BIB_W-1:0]         byte_in_block,
    input  logic                              stamp_wrapped,

    output int                                fail_count,
    output int                                rsp_count,
    output int                                lookups_open
);

    // The register index is carried by this address bit.
    localparam int REG_SEL_BIT = 3;
    localparam logic [63:0] BLK_MASK = 64'(BLOCK_BYTES - 1);

    typedef struct packed {
        logic                             hit;
        logic [bcl_pkg::WAYIDX_W-1:0]     way;
        logic [bcl_pkg::TAG_OUT_W-1:0]    tag;
        logic [bcl_pkg::FETCH_W-1:0]      fetch;
        logic [bcl_pkg::BIB_W-1:0]        bib;
        logic                             wrapped;
    } lookup_word_t;

    logic [bcl_pkg::BASE_W-1:0] buffer_base;
    logic [63:0]                way_tags [WAYS];
    logic [STAMP_BITS-1:0]      way_stamps [WAYS];
    logic [STAMP_BITS-1:0]      use_count;
    lookup_word_t               pending_lookups [$];

    // Runs one lookup against the shadow tag and stamp arrays and returns the word it yields.
    function automatic lookup_word_t resolve_lookup(input logic [63:0] off);
        lookup_word_t w;
        logic [63:0]  tag;
        logic [63:0]  pos;
        int           pick;
        bit           found;
        tag = {4'b0, off[59:0]} & ~BLK_MASK;
        if (off[63:60] != bcl_pkg::RAW_ZONE)
        begin
            tag = tag + {4'b0, buffer_base};
        end
        pick = 0;
        found = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found)
            begin
                if (i == 0 || way_stamps[pick] > way_stamps[i])
                begin
                    pick = i;
                end
                if (way_tags[i] == tag)
                begin
                    pick = i;
                    found = 1'b1;
                end
            end
        end
        if (!found)
        begin
            way_tags[pick] = tag;
        end
        use_count = use_count + STAMP_BITS'(1);
        way_stamps[pick] = use_count;
        pos = off & BLK_MASK;
        w.hit = found;
        w.way = pick[bcl_pkg::WAYIDX_W-1:0];
        w.tag = tag;
        w.fetch = tag[bcl_pkg::FETCH_W-1:0];
        w.bib = pos[bcl_pkg::BIB_W-1:0];
        w.wrapped = (use_count == '0);
        return w;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_word_t want;
        if (!rst_n)
        begin
            buffer_base = '0;
            use_count = '0;
            for (int i = 0; i < WAYS; i++)
            begin
                way_tags[i] = '1;
                way_stamps[i] = '0;
            end
            pending_lookups.delete();
            fail_count = 0;
            rsp_count <= 0;
            lookups_open <= 0;
        end
        else
        begin
            if (psel && penable && pready
                && paddr[REG_SEL_BIT] == bcl_pkg::CFG_IDX_BUFFER_BASE)
            begin
                if (pwrite)
                begin
                    buffer_base = pwdata[bcl_pkg::BASE_W-1:0];
                end
                else
                begin
                    check_field("prdata", bcl_pkg::CFG_W'(buffer_base), prdata);
                end
            end

            // Results are matched before this edge's request is predicted, since a word
            // accepted now cannot have its result out in the same cycle.
            if (rsp_valid && rsp_ready)
            begin
                rsp_count <= rsp_count + 1;
                if (pending_lookups.size() == 0)
                begin
                    $error("result word arrived with no lookup pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("way_index", want.way, way_index);
                    check_field("block_tag", want.tag, block_tag);
                    check_field("fetch_offset", want.fetch, fetch_offset);
                    check_field("byte_in_block", want.bib, byte_in_block);
                    check_field("stamp_wrapped", want.wrapped, stamp_wrapped);
                end
            end

            if (req_valid && req_ready)
            begin
                pending_lookups.push_back(resolve_lookup(disk_offset));
            end
            lookups_open <= pending_lookups.size();
        end
    end

endmodule

FILE: sim/block_cache_lru_lookup_tb.sv
// Top of the lookup testbench. It makes the clock and reset, drives the configuration
// port and the request channel, toggles the result channel's ready, and gives the
// verdict. All prediction and comparison happens in the checker instantiated beside
// the block, which hands back its failure count and how many result words it has seen.
module block_cache_lru_lookup_tb;

    localparam int WAYS        = 6;
    localparam int BLOCK_BYTES = 16384;
    localparam int STAMP_BITS  = 32;

    localparam logic [63:0] BLK_MASK = 64'(BLOCK_BYTES - 1);

    // Register addresses: the buffer base, and the next slot, which holds no register.
    localparam logic [bcl_pkg::PADDR_W-1:0] BASE_ADDR  =
        {bcl_pkg::CFG_IDX_BUFFER_BASE, 3'b000};
    localparam logic [bcl_pkg::PADDR_W-1:0] SPARE_ADDR =
        {~bcl_pkg::CFG_IDX_BUFFER_BASE, 3'b000};

    localparam int SEGMENTS          = 6;
    localparam int SEGMENT_ITEMS     = 140;
    localparam int POOL_DEPTH        = 10;
    localparam int MAX_GAP           = 20;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int TIME_LIMIT        = 5000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [bcl_pkg::PADDR_W-1:0]      paddr = '0;
    logic [bcl_pkg::CFG_W-1:0]        pwdata = '0;
    logic [bcl_pkg::CFG_W-1:0]        prdata;
    logic                             pready;

    logic                             req_valid = 1'b0;
    logic                             req_ready;
    logic [bcl_pkg::OFFSET_W-1:0]     disk_offset = '0;

    logic                             rsp_valid;
    logic                             rsp_ready = 1'b0;
    logic                             hit;
    logic [bcl_pkg::WAYIDX_W-1:0]     way_index;
    logic [bcl_pkg::TAG_OUT_W-1:0]    block_tag;
    logic [bcl_pkg::FETCH_W-1:0]      fetch_offset;
    logic [bcl_pkg::BIB_W-1:0]        byte_in_block;
    logic                             stamp_wrapped;

    int fail_count;
    int rsp_count;
    int lookups_open;

    // Stimulus bookkeeping.
    int          lookups_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stall_now = 1'b0;
    logic [59:0] cur_base = '0;
    logic [63:0] hot_blocks [POOL_DEPTH];
    int          pool_span = POOL_DEPTH;

    always #5 clk = ~clk;

    block_cache_lru_lookup #(
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .STAMP_BITS  (STAMP_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .disk_offset   (disk_offset),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .hit           (hit),
        .way_index     (way_index),
        .block_tag     (block_tag),
        .fetch_offset  (fetch_offset),
        .byte_in_block (byte_in_block),
        .stamp_wrapped (stamp_wrapped)
    );

    lru_lookup_checker #(
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .STAMP_BITS  (STAMP_BITS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .disk_offset   (disk_offset),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .hit           (hit),
        .way_index     (way_index),
        .block_tag     (block_tag),
        .fetch_offset  (fetch_offset),
        .byte_in_block (byte_in_block),
        .stamp_wrapped (stamp_wrapped),
        .fail_count    (fail_count),
        .rsp_count     (rsp_count),
        .lookups_open  (lookups_open)
    );

    // A setup cycle, an access cycle, and one idle cycle so that back-to-back transfers
    // never assign psel twice in the same step.
    task automatic apb_write(input logic [bcl_pkg::PADDR_W-1:0] addr,
                             input logic [bcl_pkg::CFG_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The checker compares prdata at the access edge.
    task automatic apb_read(input logic [bcl_pkg::PADDR_W-1:0] addr);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes the buffer base, remembers the part the block keeps, and reads it back.
    task automatic set_buffer_base(input logic [bcl_pkg::CFG_W-1:0] value);
        apb_write(BASE_ADDR, value);
        cur_base = value[bcl_pkg::BASE_W-1:0];
        apb_read(BASE_ADDR);
    endtask

    // Offers one request word, after a random gap when the sender is idling, and
    // returns in the step of the edge at which the word was taken.
    task automatic send_offset(input logic [63:0] off);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        disk_offset <= off;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        lookups_sent++;
    endtask

    // Holds the sender off until every lookup it has handed over has come back.
    task automatic drain_lookups();
        req_valid <= 1'b0;
        while (rsp_count != lookups_sent)
        begin
            @(posedge clk);
        end
    endtask

    // A block start in a random zone; about four in ten sit in the raw-volume zone.
    function automatic logic [63:0] fresh_block();
        logic [3:0]  zone;
        logic [31:0] upper;
        logic [31:0] lower;
        upper = $urandom;
        lower = $urandom;
        zone = ($urandom_range(0, 99) < 40) ? bcl_pkg::RAW_ZONE : upper[31:28];
        return {zone, upper[27:0], lower};
    endfunction

    // Builds a raw-zone offset that, with a block-aligned base, lands on the same tag as
    // a rebased block, sharing one way. Only possible while the rebased tag fits in 60 bits.
    function automatic bit raw_alias(input logic [63:0] blk, output logic [63:0] alias_off);
        logic [63:0] tag;
        logic [31:0] pos;
        pos = $urandom;
        tag = ({4'b0, blk[59:0]} & ~BLK_MASK) + {4'b0, cur_base};
        alias_off = ({bcl_pkg::RAW_ZONE, tag[59:0]} & ~BLK_MASK) | ({32'b0, pos} & BLK_MASK);
        return (blk[63:60] != bcl_pkg::RAW_ZONE) && (tag[63:60] == 4'b0);
    endfunction

    // Mostly hot blocks, so that hits, evictions and least-recent picks all occur,
    // plus cross-zone aliases and fully random offsets as noise.
    function automatic logic [63:0] pick_offset();
        logic [63:0] blk;
        logic [63:0] alias_off;
        logic [31:0] pos;
        int          roll;
        roll = $urandom_range(0, 99);
        pos = $urandom;
        blk = hot_blocks[$urandom_range(0, pool_span - 1)];
        if (roll < 10)
        begin
            return {$urandom, $urandom};
        end
        if (roll < 22 && raw_alias(blk, alias_off))
        begin
            return alias_off;
        end
        return (blk & ~BLK_MASK) | ({32'b0, pos} & BLK_MASK);
    endfunction

    // The receiver. Besides its random idling it honors a request for one long
    // hold-off, which it counts itself while the sender keeps offering words.
    initial
    begin : receiver
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_now)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                stall_now = 1'b0;
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [63:0] alias_off;
        logic [63:0] base_word;
        logic [63:0] blk;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            hot_blocks[i] = fresh_block();
        end

        send_idle_pct = 26;
        recv_idle_pct = 52;

        // With a zero base: all-zero and all-one offsets, the top of the raw zone, a hit
        // on the last byte of a block already held, then enough new blocks to fill every
        // way.
        send_offset(64'h0000_0000_0000_0000);
        send_offset(64'hFFFF_FFFF_FFFF_FFFF);
        send_offset(64'h1FFF_FFFF_FFFF_FFFF);
        send_offset(64'h0000_0000_0000_3FFF);
        for (int k = 1; k <= 4; k++)
        begin
            send_offset(64'(k) << 14);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // The base only changes once the block has handed back every word.
            drain_lookups();

            // Sender idles lightly then heavily, the receiver the other way round, and
            // the last third runs with neither idling.
            send_idle_pct = (seg < 2) ? 26 : (seg < 4) ? 52 : 0;
            recv_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 26 : 0;
            pool_span = $urandom_range(4, POOL_DEPTH);

            unique case (seg)
                0: base_word = '1;
                1: base_word = {$urandom, $urandom} & ~BLK_MASK & 64'h00FF_FFFF_FFFF_FFFF;
                3: base_word = '0;
                5: base_word = {32'b0, $urandom};
                default: base_word = {$urandom, $urandom};
            endcase
            set_buffer_base(base_word);

            if (seg == 0)
            begin
                // A write to the empty slot must leave the base alone.
                apb_write(SPARE_ADDR, {$urandom, $urandom});
                apb_read(BASE_ADDR);
                // With the largest base: a rebased tag that carries into bit 60, the
                // raw zone's block zero, and a zone whose tag is the base itself.
                send_offset(64'h0FFF_FFFF_FFFF_C000);
                send_offset(64'h1000_0000_0000_0000);
                send_offset(64'h2000_0000_0000_0123);
            end
            else if (seg == 1)
            begin
                // A rebased block followed by the raw-zone offset that aliases it.
                blk = 64'h3000_0000_1234_5678;
                send_offset(blk);
                if (raw_alias(blk, alias_off))
                begin
                    send_offset(alias_off);
                end
            end
            else if (seg == 4)
            begin
                // Long receiver hold-off with the sender at full rate: the block fills
                // up and has to stall its request channel.
                stall_now = 1'b1;
            end

            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    hot_blocks[$urandom_range(0, POOL_DEPTH - 1)] = fresh_block();
                end
                send_offset(pick_offset());
            end
        end

        drain_lookups();
        repeat (2 * (WAYS + 3)) @(posedge clk);

        if (fail_count == 0 && lookups_open == 0)
        begin
            $display("block_cache_lru_lookup: match");
        end
        else
        begin
            $display("block_cache_lru_lookup: mismatch");
        end
        $finish;
    end

    // Generous cap on the whole run in case a handshake never completes.
    initial
    begin : watchdog
        #(TIME_LIMIT);
        $display("block_cache_lru_lookup: mismatch");
        $finish;
    end

endmodule
